/* hdl/spectral_bin_correlation_tracker_assert.svh */
// Assertion macros for the tracker RTL.
// Needs clk and rst_n in the scope of every use.
`ifndef SPECTRAL_BIN_CORRELATION_TRACKER_ASSERT_SVH
`define SPECTRAL_BIN_CORRELATION_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define SBCT_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define SBCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SBCT_ASSERT(label, expr, msg)
`define SBCT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* hdl/sbct_pkg.sv */
// Types and constants of the spectral bin correlation tracker.
// No dependencies; imported by every module of the block.
`default_nettype none
package sbct_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_BINS    = 4097;
    localparam int MODE_COUNT  = 3;
    localparam int STORE_DEPTH = MODE_COUNT * MAX_BINS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BIN_W       = 13;
    localparam int COEF_W      = 16;
    localparam int ALPHA_W     = 16;

    localparam int MAG_W  = SAMPLE_BITS;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int E_W    = SQ_W + 1;
    localparam int DIV_W  = SQ_W + 2;
    localparam int ROOT_STEPS = MAG_W;
    localparam int QUOT_STEPS = 14;
    localparam int Q_W        = QUOT_STEPS + 1;
    localparam int FRONT_STAGES = 3 + ROOT_STEPS + 2 + 1 + QUOT_STEPS + 1;
    localparam int PROD_W = ALPHA_W + COEF_W + 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = ((BIN_W + 4 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((BIN_W + 2 * COEF_W + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic signed [COEF_W-1:0] ONE_Q14 = COEF_W'(16384);
    localparam logic [COEF_W-1:0]        SAT_Q14 = COEF_W'(32767);
    localparam logic [ALPHA_W:0]         ALPHA_ONE = (ALPHA_W+1)'(1) << ALPHA_W;
    localparam logic [PROD_W-1:0]        ROUND_HALF = PROD_W'(1) << (ALPHA_W - 1);

    typedef enum logic [1:0] {
        MODE_PHASE,
        MODE_FREQ,
        MODE_ENERGY
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE,
        REG_ALPHA,
        REG_FLOOR,
        REG_CEIL,
        REG_FFLOOR,
        REG_BINS
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]                mode;
        logic [ALPHA_W-1:0]        alpha;
        logic signed [COEF_W-1:0]  floor_q;
        logic signed [COEF_W-1:0]  ceil_q;
        logic signed [COEF_W-1:0]  ffloor_q;
        logic [BIN_W-1:0]          bin_count;
    } cfg_t;

    // one classified item handed from the front to the store stage
    typedef struct packed {
        logic [BIN_W-1:0]          bin;
        logic [ADDR_W-1:0]         addr;
        logic                      oor;
        logic signed [COEF_W-1:0]  coef;
    } item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0]  min_q;
        logic signed [COEF_W-1:0]  avg_q;
        logic [BIN_W-1:0]          bin;
    } result_t;

endpackage
`default_nettype wire

/* hdl/sbct_front.sv */
// Front pipeline: magnitudes, products, square roots, ratio and clamp.
// Uses sbct_pkg; feeds sbct_queue with one classified item per cycle unless the queue is full.
`default_nettype none
module sbct_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sbct_pkg::cfg_t                        cfg,
    input  logic                                  hold,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [sbct_pkg::BIN_W-1:0]            bin_index,
    input  logic signed [sbct_pkg::SAMPLE_BITS-1:0] left_re,
    input  logic signed [sbct_pkg::SAMPLE_BITS-1:0] left_im,
    input  logic signed [sbct_pkg::SAMPLE_BITS-1:0] right_re,
    input  logic signed [sbct_pkg::SAMPLE_BITS-1:0] right_im,
    output logic                                  push_valid,
    output sbct_pkg::item_t                       push_item,
    input  logic                                  queue_full
);
    import sbct_pkg::*;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        mode_t            mode;
        logic             oor;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [MAG_W-1:0] lr, li, rr, ri;
        logic             nlr, nli, nrr, nri;
    } s1_t;

    typedef struct packed {
        tag_t            tag;
        logic [SQ_W-1:0] sq_lr, sq_li, sq_rr, sq_ri, p1, p2;
        logic            n1, n2;
    } s2_t;

    typedef struct packed {
        logic [SQ_W-1:0] x;
        logic [SQ_W-1:0] r;
    } root_pair_t;

    typedef struct packed {
        tag_t            tag;
        logic [SQ_W-1:0] xmag;
        logic            xneg;
        logic [E_W-1:0]  e;
        root_pair_t      lp, rp;
    } root_st_t;

    typedef struct packed {
        tag_t            tag;
        logic [SQ_W-1:0] xmag;
        logic            xneg;
        logic [E_W-1:0]  e;
        logic [SQ_W-1:0] d;
    } s4_t;

    typedef struct packed {
        tag_t             tag;
        logic             xneg;
        logic             zero;
        logic             sat;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
        logic [Q_W-1:0]   q;
    } div_st_t;

    function automatic root_pair_t root_step(root_pair_t p, logic [SQ_W-1:0] b);
        root_pair_t o;
        logic [SQ_W-1:0] trial;
        trial = p.r + b;
        if (p.x >= trial)
        begin
            o.x = p.x - trial;
            o.r = (p.r >> 1) + b;
        end
        else
        begin
            o.x = p.x;
            o.r = p.r >> 1;
        end
        return o;
    endfunction

    function automatic logic [MAG_W-1:0] magnitude(logic signed [SAMPLE_BITS-1:0] v);
        return v[SAMPLE_BITS-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
    endfunction

    logic                        en;
    logic                        in_acc;
    logic [FRONT_STAGES-1:0]     vld_reg;
    s1_t                         s1_reg;
    s2_t                         s2_reg;
    root_st_t                    s3_reg, s3_next;
    root_st_t                    root_reg [ROOT_STEPS];
    s4_t                         s4_reg;
    div_st_t                     s5_reg, s5_next;
    div_st_t                     div_reg [QUOT_STEPS+1];
    div_st_t                     pre_next;
    item_t                       fin_reg, fin_next;
    mode_t                       mode_in;

    // whole pipe moves together; it only stops when the queue is full and the last stage holds an item
    assign en         = !vld_reg[FRONT_STAGES-1] || !queue_full;
    assign in_ready   = en && !hold;
    assign in_acc     = in_valid && in_ready;
    assign push_valid = vld_reg[FRONT_STAGES-1];
    assign push_item  = fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_acc};
    end

    // unused mode code behaves as energy mode
    assign mode_in = (cfg.mode == 2'd3) ? MODE_ENERGY : mode_t'(cfg.mode);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg.tag.bin  <= bin_index;
            s1_reg.tag.mode <= mode_in;
            s1_reg.tag.oor  <= (bin_index >= cfg.bin_count) ||
                               (bin_index >= BIN_W'(MAX_BINS));
            s1_reg.lr  <= magnitude(left_re);
            s1_reg.li  <= magnitude(left_im);
            s1_reg.rr  <= magnitude(right_re);
            s1_reg.ri  <= magnitude(right_im);
            s1_reg.nlr <= left_re[SAMPLE_BITS-1];
            s1_reg.nli <= left_im[SAMPLE_BITS-1];
            s1_reg.nrr <= right_re[SAMPLE_BITS-1];
            s1_reg.nri <= right_im[SAMPLE_BITS-1];

            s2_reg.tag   <= s1_reg.tag;
            s2_reg.sq_lr <= s1_reg.lr * s1_reg.lr;
            s2_reg.sq_li <= s1_reg.li * s1_reg.li;
            s2_reg.sq_rr <= s1_reg.rr * s1_reg.rr;
            s2_reg.sq_ri <= s1_reg.ri * s1_reg.ri;
            s2_reg.p1    <= s1_reg.lr * s1_reg.rr;
            s2_reg.p2    <= s1_reg.li * s1_reg.ri;
            s2_reg.n1    <= s1_reg.nlr ^ s1_reg.nrr;
            s2_reg.n2    <= s1_reg.nli ^ s1_reg.nri;

            s3_reg <= s3_next;
        end
    end

    // energies and signed cross term as sign and magnitude
    always_comb
    begin
        s3_next      = '0;
        s3_next.tag  = s2_reg.tag;
        s3_next.lp.x = s2_reg.sq_lr + s2_reg.sq_li;
        s3_next.rp.x = s2_reg.sq_rr + s2_reg.sq_ri;
        s3_next.e    = E_W'(s3_next.lp.x) + E_W'(s3_next.rp.x);
        if (s2_reg.n1 == s2_reg.n2)
        begin
            s3_next.xmag = s2_reg.p1 + s2_reg.p2;
            s3_next.xneg = s2_reg.n1;
        end
        else if (s2_reg.p1 >= s2_reg.p2)
        begin
            s3_next.xmag = s2_reg.p1 - s2_reg.p2;
            s3_next.xneg = s2_reg.n1;
        end
        else
        begin
            s3_next.xmag = s2_reg.p2 - s2_reg.p1;
            s3_next.xneg = s2_reg.n2;
        end
        if (s3_next.xmag == '0)
            s3_next.xneg = 1'b0;
    end

    // two square roots, one result bit per stage
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        root_st_t stage_in, stage_next;
        if (k == 0)
        begin : g_first
            assign stage_in = s3_reg;
        end
        else
        begin : g_rest
            assign stage_in = root_reg[k-1];
        end
        always_comb
        begin
            stage_next    = stage_in;
            stage_next.lp = root_step(stage_in.lp, STEP_BIT);
            stage_next.rp = root_step(stage_in.rp, STEP_BIT);
        end
        always_ff @(posedge clk)
        begin
            if (en)
                root_reg[k] <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg.tag  <= root_reg[ROOT_STEPS-1].tag;
            s4_reg.xmag <= root_reg[ROOT_STEPS-1].xmag;
            s4_reg.xneg <= root_reg[ROOT_STEPS-1].xneg;
            s4_reg.e    <= root_reg[ROOT_STEPS-1].e;
            s4_reg.d    <= root_reg[ROOT_STEPS-1].lp.r[MAG_W-1:0] *
                           root_reg[ROOT_STEPS-1].rp.r[MAG_W-1:0];
            s5_reg      <= s5_next;
            div_reg[0]  <= pre_next;
        end
    end

    // pick numerator and denominator by mode
    always_comb
    begin
        s5_next      = '0;
        s5_next.tag  = s4_reg.tag;
        s5_next.xneg = s4_reg.xneg;
        if (s4_reg.tag.mode == MODE_PHASE)
        begin
            s5_next.num  = DIV_W'(s4_reg.xmag);
            s5_next.den  = DIV_W'(s4_reg.d);
            s5_next.zero = (s4_reg.d == '0);
        end
        else
        begin
            s5_next.num  = (s4_reg.tag.mode == MODE_FREQ) ? DIV_W'(s4_reg.d) << 1
                                                          : DIV_W'(s4_reg.xmag) << 1;
            s5_next.den  = DIV_W'(s4_reg.e);
            s5_next.zero = (s4_reg.e == '0);
        end
    end

    // integer part: ratio of two or more saturates
    always_comb
    begin
        pre_next = s5_reg;
        if (s5_reg.num >= s5_reg.den)
        begin
            pre_next.num = s5_reg.num - s5_reg.den;
            pre_next.sat = (pre_next.num >= s5_reg.den);
            pre_next.q   = Q_W'(1);
        end
    end

    // restoring division, one fraction bit per stage
    for (genvar k = 1; k <= QUOT_STEPS; k++)
    begin : g_div
        div_st_t stage_next;
        logic [DIV_W-1:0] twice;
        assign twice = div_reg[k-1].num << 1;
        always_comb
        begin
            stage_next = div_reg[k-1];
            if (twice >= div_reg[k-1].den)
            begin
                stage_next.num = twice - div_reg[k-1].den;
                stage_next.q   = {div_reg[k-1].q[Q_W-2:0], 1'b1};
            end
            else
            begin
                stage_next.num = twice;
                stage_next.q   = {div_reg[k-1].q[Q_W-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
                div_reg[k] <= stage_next;
        end
    end

    // sign, clamp (floor tested first), store address
    always_comb
    begin
        div_st_t                  d;
        logic [COEF_W-1:0]        qv;
        logic signed [COEF_W-1:0] sv;
        logic signed [COEF_W-1:0] lo;
        d  = div_reg[QUOT_STEPS];
        qv = d.sat ? SAT_Q14 : COEF_W'(d.q);
        sv = (d.xneg && d.tag.mode != MODE_FREQ) ? -$signed(qv) : $signed(qv);
        lo = (d.tag.mode == MODE_FREQ) ? cfg.ffloor_q : cfg.floor_q;
        fin_next.bin = d.tag.bin;
        fin_next.oor = d.tag.oor;
        if (d.zero)
            fin_next.coef = ONE_Q14;
        else if (sv < lo)
            fin_next.coef = lo;
        else if (sv > cfg.ceil_q)
            fin_next.coef = cfg.ceil_q;
        else
            fin_next.coef = sv;
        unique case (d.tag.mode)
            MODE_PHASE: fin_next.addr = ADDR_W'(d.tag.bin);
            MODE_FREQ:  fin_next.addr = ADDR_W'(MAX_BINS) + ADDR_W'(d.tag.bin);
            default:    fin_next.addr = ADDR_W'(2 * MAX_BINS) + ADDR_W'(d.tag.bin);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fin_reg <= fin_next;
    end

endmodule
`default_nettype wire

/* hdl/sbct_queue.sv */
// Short queue between the front pipeline and the store stage.
// Uses sbct_pkg and the tracker assertion macros.
`default_nettype none
`include "spectral_bin_correlation_tracker_assert.svh"
module sbct_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sbct_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output sbct_pkg::item_t head,
    output logic            empty
);
    import sbct_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    `SBCT_ASSERT(a_cnt_bound, cnt_reg <= QCNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `SBCT_ASSERT(a_push_room, !(push && full), "push into a full queue")
    `SBCT_ASSERT_NEXT(a_pop_drains, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1, "pop lost")

endmodule
`default_nettype wire

/* hdl/sbct_back.sv */
// Store stage: per mode and bin average and minimum, clearing pass.
// Uses sbct_pkg; takes items from sbct_queue, drives the result register.
`default_nettype none
module sbct_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sbct_pkg::ALPHA_W-1:0] alpha,
    input  logic                        clr_start,
    output logic                        clr_busy,
    input  sbct_pkg::item_t             head,
    input  logic                        empty,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sbct_pkg::result_t           out_data
);
    import sbct_pkg::*;

    logic [2*COEF_W-1:0] mem [STORE_DEPTH];
    logic [2*COEF_W-1:0] rdata_reg;
    item_t               b_reg;
    logic                b_valid_reg;
    logic                adv;
    logic                out_valid_reg;
    result_t             out_reg, out_next;
    logic                lw_valid_reg;
    logic [ADDR_W-1:0]   lw_addr_reg;
    logic [2*COEF_W-1:0] lw_data_reg;
    logic                clr_busy_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic [2*COEF_W-1:0] old_entry, new_entry;
    logic signed [COEF_W-1:0] old_avg, old_min, avg_q, min_q;
    logic signed [PROD_W-1:0] keep_prod, new_prod, acc;
    logic [ALPHA_W:0]    rest_w;
    logic                item_we;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [2*COEF_W-1:0] mem_wdata;

    assign adv       = !out_valid_reg || out_ready;
    assign pop       = adv && !empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign clr_busy  = clr_busy_reg;

    // the entry read with this item missed the write of the one just before
    assign old_entry = (lw_valid_reg && lw_addr_reg == b_reg.addr) ? lw_data_reg : rdata_reg;
    assign old_avg   = old_entry[COEF_W-1:0];
    assign old_min   = old_entry[2*COEF_W-1:COEF_W];
    assign rest_w    = ALPHA_ONE - {1'b0, alpha};
    assign keep_prod = $signed({1'b0, alpha}) * old_avg;
    assign new_prod  = $signed({1'b0, rest_w}) * b_reg.coef;
    assign acc       = keep_prod + new_prod + $signed(ROUND_HALF);
    assign avg_q     = acc[COEF_W+ALPHA_W-1:ALPHA_W];
    assign min_q     = (avg_q < old_min) ? avg_q : old_min;
    assign new_entry = {min_q, avg_q};
    assign item_we   = adv && b_valid_reg && !b_reg.oor && !clr_busy_reg;

    always_comb
    begin
        out_next.bin = b_reg.bin;
        if (b_reg.oor)
        begin
            out_next.avg_q = '0;
            out_next.min_q = '0;
        end
        else
        begin
            out_next.avg_q = avg_q;
            out_next.min_q = min_q;
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = {ONE_Q14, ONE_Q14};
        end
        else
        begin
            mem_we    = item_we;
            mem_waddr = b_reg.addr;
            mem_wdata = new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (adv)
            rdata_reg <= mem[head.addr];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg   <= head;
            out_reg <= out_next;
        end
        if (item_we)
        begin
            lw_addr_reg <= b_reg.addr;
            lw_data_reg <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (adv)
            begin
                b_valid_reg   <= !empty;
                out_valid_reg <= b_valid_reg;
            end
            if (clr_start || clr_busy_reg)
                lw_valid_reg <= 1'b0;
            else if (item_we)
                lw_valid_reg <= 1'b1;
            if (clr_start)
            begin
                clr_busy_reg <= 1'b1;
                clr_cnt_reg  <= '0;
            end
            else if (clr_busy_reg)
            begin
                if (clr_cnt_reg == ADDR_W'(STORE_DEPTH - 1))
                    clr_busy_reg <= 1'b0;
                else
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/spectral_bin_correlation_tracker.sv */
// Top level of the spectral bin correlation tracker: register file and wiring.
// Uses sbct_pkg, sbct_front, sbct_queue and sbct_back.
//
// Usage:
//   s_axis carries one stereo FFT bin per item; m_axis returns one result
//   per item, in order: the bin number, the updated average and the minimum
//   of that average, both Q1.14, kept per correlation mode and bin.
//   Items with a bin at or above bin_count or MAX_BINS give zero average and minimum.
//   cfg_we/cfg_index/cfg_data write one of the six registers at a time.
// Throughput: one item per cycle, sustained while m_axis_tready is high and no sweep runs.
// Pipeline: from input accept to result valid an item passes 48
//   registers, the first loaded at the accept edge: 45 in the front pipeline
//   (two 24-stage square roots and a 15-stage divider dominate), one in the
//   queue and two in the store read-modify-write.
// Reset: the 12291-entry store is swept to 1.0, one entry per cycle,
//   so s_axis_tready stays low until the sweep ends. Writing a new bin_count
//   starts the same sweep. Config writes are taken at any time.
// Stall: with m_axis_tready low the result holds, a 4-entry queue absorbs
//   items in flight, then the whole front pipeline stops and
//   s_axis_tready drops.
`default_nettype none
module spectral_bin_correlation_tracker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // bin_index, left_re, left_im, right_re, right_im, zero pad
    input  logic [sbct_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_bin, avg_coef, min_coef
    output logic [sbct_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    input  logic                                   cfg_we,
    input  logic [sbct_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [sbct_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import sbct_pkg::*;

    cfg_t    cfg_reg;
    logic    clr_start;
    logic    clr_busy;
    logic    push_valid;
    item_t   push_item;
    logic    q_full, q_empty, q_pop;
    item_t   q_head;
    result_t res;

    // a changed bin count restarts the store sweep
    assign clr_start = cfg_we && (cfg_reg_t'(cfg_index) == REG_BINS) &&
                       (cfg_data[BIN_W-1:0] != cfg_reg.bin_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= 2'(MODE_PHASE);
            cfg_reg.alpha     <= ALPHA_W'(52429);
            cfg_reg.floor_q   <= -ONE_Q14;
            cfg_reg.ceil_q    <= ONE_Q14;
            cfg_reg.ffloor_q  <= '0;
            cfg_reg.bin_count <= BIN_W'(MAX_BINS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MODE:   cfg_reg.mode      <= cfg_data[1:0];
                REG_ALPHA:  cfg_reg.alpha     <= cfg_data[ALPHA_W-1:0];
                REG_FLOOR:  cfg_reg.floor_q   <= $signed(cfg_data[COEF_W-1:0]);
                REG_CEIL:   cfg_reg.ceil_q    <= $signed(cfg_data[COEF_W-1:0]);
                REG_FFLOOR: cfg_reg.ffloor_q  <= $signed(cfg_data[COEF_W-1:0]);
                REG_BINS:   cfg_reg.bin_count <= cfg_data[BIN_W-1:0];
                default:    ;
            endcase
        end
    end

    sbct_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .hold       (clr_busy),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .bin_index  (s_axis_tdata[BIN_W-1:0]),
        .left_re    (s_axis_tdata[BIN_W +: SAMPLE_BITS]),
        .left_im    (s_axis_tdata[BIN_W + SAMPLE_BITS +: SAMPLE_BITS]),
        .right_re   (s_axis_tdata[BIN_W + 2 * SAMPLE_BITS +: SAMPLE_BITS]),
        .right_im   (s_axis_tdata[BIN_W + 3 * SAMPLE_BITS +: SAMPLE_BITS]),
        .push_valid (push_valid),
        .push_item  (push_item),
        .queue_full (q_full)
    );

    sbct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid && !q_full),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    sbct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .alpha     (cfg_reg.alpha),
        .clr_start (clr_start),
        .clr_busy  (clr_busy),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = OUT_TDATA_W'(res);

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for spectral_bin_correlation_tracker: directed and random stereo bins.
// Depends on sbct_pkg and the tracker RTL; predicts every result in-bench.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import sbct_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // bin_index, left_re, left_im, right_re, right_im, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // out_bin, avg_coef, min_coef
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    spectral_bin_correlation_tracker u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial forever #2 clk = ~clk;

    // ---------------------------------------------------------------
    // bench copy of the registers and the two per-mode, per-bin stores
    // ---------------------------------------------------------------
    int unsigned m_mode, m_alpha, m_bins;
    int          m_floor, m_ceil, m_ffloor;
    int          avg_mem [STORE_DEPTH];
    int          min_mem [STORE_DEPTH];

    result_t     pending_results[$];
    int          errors = 0;
    bit          idle_on = 1'b0;     // random idling on both sides
    int          hold_off = 0;       // receiver hold-off, in cycles

    function automatic void fill_one();
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            avg_mem[i] = 16384;
            min_mem[i] = 16384;
        end
    endfunction

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // floor(num * 2^14 / den), saturated at 32767
    function automatic int q14_ratio(longint unsigned num, longint unsigned den);
        logic [127:0] p;
        if (num >= 2 * den)
            return 32767;
        p = {64'd0, num} << 14;
        return int'(p / {64'd0, den});
    endfunction

    function automatic int clamp_q(int v, int lo, int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int corr_q14(int unsigned mode, int lre, int lim, int rre, int rim);
        longint          el, er, x;
        longint unsigned xm, den, num;
        int              q;
        el = longint'(lre) * lre + longint'(lim) * lim;
        er = longint'(rre) * rre + longint'(rim) * rim;
        x  = longint'(lre) * rre + longint'(lim) * rim;
        xm = (x < 0) ? -x : x;
        if (mode == MODE_PHASE)
        begin
            den = root_floor(el) * root_floor(er);
            if (den == 0)
                return 16384;          // a silent channel: no clamp
            q = q14_ratio(xm, den);
            return clamp_q((x < 0) ? -q : q, m_floor, m_ceil);
        end
        den = el + er;
        if (den == 0)
            return 16384;
        num = (mode == MODE_FREQ) ? root_floor(el) * root_floor(er) : xm;
        q = q14_ratio(2 * num, den);
        if (mode == MODE_FREQ)
            return clamp_q(q, m_ffloor, m_ceil);
        return clamp_q((x < 0) ? -q : q, m_floor, m_ceil);
    endfunction

    // advance the bench stores for one accepted item, queue its result
    function automatic void track_bin(logic [IN_TDATA_W-1:0] d);
        result_t     r;
        int unsigned bin, mode, idx;
        int          v, avg;
        longint      s;
        bin = d[12:0];
        r.bin = bin;
        if (bin >= m_bins || bin >= MAX_BINS)
        begin
            r.avg_q = '0;
            r.min_q = '0;
        end
        else
        begin
            mode = (m_mode > 2) ? MODE_ENERGY : m_mode;   // spare code acts as energy
            idx = mode * MAX_BINS + bin;
            v = corr_q14(mode, int'($signed(d[36:13])), int'($signed(d[60:37])),
                         int'($signed(d[84:61])), int'($signed(d[108:85])));
            s = longint'(m_alpha) * avg_mem[idx] + longint'(65536 - m_alpha) * v + 32768;
            avg = int'(s >>> 16);
            avg_mem[idx] = avg;
            if (avg < min_mem[idx])
                min_mem[idx] = avg;
            r.avg_q = avg[15:0];
            r.min_q = min_mem[idx][15:0];
        end
        pending_results.push_back(r);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // result side: hold-off, random stalls, in-order compare
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= !(idle_on && $urandom_range(99) < 29);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                report("unexpected item, bin", m_axis_tdata[12:0], -1);
            else
            begin
                result_t w;
                w = pending_results.pop_front();
                if (m_axis_tdata[12:0] != w.bin)
                    report("out_bin", m_axis_tdata[12:0], w.bin);
                if (m_axis_tdata[28:13] != w.avg_q)
                    report("avg_coef", $signed(m_axis_tdata[28:13]), w.avg_q);
                if (m_axis_tdata[44:29] != w.min_q)
                    report("min_coef", $signed(m_axis_tdata[44:29]), w.min_q);
            end
        end
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------
    task automatic send_bin(int bin, int lre, int lim, int rre, int rim);
        while (idle_on && $urandom_range(99) < 29)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {3'b0, rim[23:0], rre[23:0], lim[23:0], lre[23:0], bin[12:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_bin(s_axis_tdata);
        @(negedge clk);
    endtask

    // wait for all results, then keep idling for safety
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // registers only change with the block empty
    task automatic write_reg(cfg_reg_t r, int val);
        drain();
        cfg_we    = 1'b1;
        cfg_index = r;
        cfg_data  = val[15:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (r)
            REG_MODE:   m_mode = val & 3;
            REG_ALPHA:  m_alpha = val & 16'hffff;
            REG_FLOOR:  m_floor = int'($signed(val[15:0]));
            REG_CEIL:   m_ceil = int'($signed(val[15:0]));
            REG_FFLOOR: m_ffloor = int'($signed(val[15:0]));
            REG_BINS:
            begin
                if ((val & 13'h1fff) != m_bins)
                    fill_one();       // new bin count wipes the stores
                m_bins = val & 13'h1fff;
            end
            default: ;
        endcase
    endtask

    function automatic int rand_sample();
        case ($urandom_range(5))
            0: return -8388608;
            1: return 8388607;
            2: return $urandom_range(15) - 8;
            3: return 0;
            default: return int'($signed($urandom_range(24'hffffff, 0) & 24'hffffff)) << 8 >>> 8;
        endcase
    endfunction

    function automatic int rand_bin();
        if ($urandom_range(19) == 0)
            return $urandom_range(4096);       // mostly out of range when bins are few
        if ($urandom_range(3) == 0)
            return 0;
        return $urandom_range(m_bins > 1 ? m_bins - 1 : 0);
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_directed();
        for (int md = 0; md < 4; md++)
        begin
            write_reg(REG_MODE, md);
            send_bin(0, 0, 0, 0, 0);                         // both channels silent
            send_bin(1, 0, 0, 1000, -5);                     // one channel silent
            send_bin(2, 8388607, 8388607, 8388607, 8388607);
            send_bin(2, -8388608, -8388608, 8388607, 8388607);
            send_bin(4096, -8388608, 8388607, -8388608, 8388607);
        end
        drain();
        // floor above ceiling, narrow clamps, tiny alpha
        write_reg(REG_FLOOR, 8000);
        write_reg(REG_CEIL, -3000);
        write_reg(REG_FFLOOR, 16384);
        write_reg(REG_ALPHA, 0);
        for (int md = 0; md < 3; md++)
        begin
            write_reg(REG_MODE, md);
            send_bin(3, 100, 20, -90, 7);
            send_bin(3, 100, 20, 90, 7);
        end
        drain();
        write_reg(REG_BINS, 4097);                           // same value: no wipe
        write_reg(REG_BINS, 4);
        send_bin(3, 5, 5, 5, 5);
        send_bin(4, 5, 5, 5, 5);                             // just past bin_count
        drain();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_bin(rand_bin(), rand_sample(), rand_sample(), rand_sample(), rand_sample());
    endtask

    task automatic test_settings();
        int bins_list [5] = '{1, 4097, 16, 3, 600};
        for (int p = 0; p < 5; p++)
        begin
            drain();
            write_reg(REG_BINS, bins_list[p]);
            write_reg(REG_MODE, $urandom_range(3));
            write_reg(REG_ALPHA, (p == 0) ? 65535 : (p == 1) ? 0 : $urandom_range(65535));
            write_reg(REG_FLOOR, (p == 2) ? -16384 : $urandom_range(32768) - 16384);
            write_reg(REG_CEIL, (p == 2) ? 16384 : $urandom_range(32768) - 16384);
            write_reg(REG_FFLOOR, (p == 3) ? -16384 : $urandom_range(32768) - 16384);
            idle_on = (p != 1);                              // one phase at full rate
            test_random(320);
        end
        drain();
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_off = 400;                                      // receiver blocks, queue fills
        test_random(370);
        idle_on = 1'b1;
        drain();
    endtask

    initial
    begin
        m_mode = 0; m_alpha = 52429; m_floor = -16384; m_ceil = 16384;
        m_ffloor = 0; m_bins = 4097;
        fill_one();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        idle_on = 1'b1;
        test_settings();
        test_backpressure();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
